>>> design/wavetable_oscillator_core_defines.svh
// Assertion macros used by the checker file.
`ifndef WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define WTO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wto assertion failed");

// Next-cycle implication, disabled while in reset.
`define WTO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wto assertion failed");

`endif

>>> design/wto_pkg.sv
package wto_pkg;

  // Table geometry and sample format
  localparam int TABLE_DEPTH = 2048;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PHASE_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = PHASE_W + LEN_W;

  // Config bus geometry
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_INC   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIX   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FREE  = 3'd4;

  // Input commands
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_WR_A      = 2'd1,
    CMD_WR_B      = 2'd2,
    CMD_PHASE_RST = 2'd3
  } wto_cmd_e;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic [PHASE_W-1:0] phase_increment;
    logic [LEN_W-1:0]   table_length;
    logic [FRAC_W-1:0]  wave_mix;
    logic [PHASE_W-1:0] start_phase;
    logic               free_running;
  } wto_cfg_t;

endpackage

>>> design/wavetable_oscillator_core.sv
// Channel   | Dir | Handshake                  | Word
// ----------+-----+----------------------------+---------------------------------------
// in        | in  | in_valid_i / in_stall_o    | command, entry_address, entry_value, fm
// out       | out | out_valid_o / out_stall_i  | sample
// config    | in  | psel/penable/pwrite/pready | APB registers at 4*index
//
// A table write or phase reset completes on acceptance; a sample tick holds the input
// until its steps are done: add, index multiply, two table reads, interpolate, crossfade.
// The two entries per table come through the single read port of each RAM.
// The result sits in an output register, so the next word is taken while it waits.
// A stalled output holds a tick in the crossfade step until the register frees.
// Reset clears phase and sets config registers to defaults; table contents are unknown until written.
module wavetable_oscillator_core
  import wto_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [ADDR_W-1:0]             entry_address_i,
  input  logic signed [SAMPLE_BITS-1:0] entry_value_i,
  input  logic [PHASE_W-1:0]            fm_phase_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RD1,
    ST_RD2,
    ST_INTERP,
    ST_MIX
  } state_e;

  state_e                  state_q;
  wto_cfg_t                cfg;
  wto_cmd_e                cmd;
  logic                    accept;
  logic                    out_free;
  logic                    out_valid_q;
  logic [PHASE_W-1:0]      phase_q;
  logic [PHASE_W-1:0]      p_q;
  logic [PROD_W-1:0]       prod_d;
  logic [PROD_W-1:0]       prod_q;
  logic [LEN_W-1:0]        len_eff;
  logic [ADDR_W-1:0]       i1;
  logic [LEN_W-1:0]        i1_inc;
  logic [ADDR_W-1:0]       i2_d;
  logic [ADDR_W-1:0]       i2_q;
  logic [FRAC_W-1:0]       frac;
  logic [ADDR_W-1:0]       raddr;
  logic                    wr_ok;
  logic                    we_a;
  logic                    we_b;
  logic [SAMPLE_BITS-1:0]  rdata_a;
  logic [SAMPLE_BITS-1:0]  rdata_b;
  logic signed [SAMPLE_BITS-1:0] s1a_q;
  logic signed [SAMPLE_BITS-1:0] s1b_q;
  logic signed [SAMPLE_BITS-1:0] wa;
  logic signed [SAMPLE_BITS-1:0] wb;

  assign pready = 1'b1;

  wto_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Handshake
  assign cmd        = wto_cmd_e'(command_i);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Table writes go straight in on accept
  assign wr_ok = ({1'b0, entry_address_i} < (ADDR_W + 1)'(TABLE_DEPTH));
  assign we_a  = accept && (cmd == CMD_WR_A) && wr_ok;
  assign we_b  = accept && (cmd == CMD_WR_B) && wr_ok;

  // Clamped table length
  always_comb begin
    if (cfg.table_length < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (cfg.table_length > LEN_W'(TABLE_DEPTH)) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff = cfg.table_length;
    end
  end

  // Index and fraction from the scaled phase
  assign prod_d = p_q * len_eff;
  assign i1     = prod_q[PHASE_W +: ADDR_W];
  assign frac   = prod_q[PHASE_W-1 -: FRAC_W];
  assign i1_inc = LEN_W'(i1) + LEN_W'(1);
  assign i2_d   = (i1_inc >= len_eff) ? '0 : i1_inc[ADDR_W-1:0];
  assign raddr  = (state_q == ST_RD1) ? i1 : i2_q;

  wto_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (entry_address_i),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  wto_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (entry_address_i),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  // Interpolation within each table
  wto_blend u_interp_a (
    .clk_i   (clk_i),
    .en_i    (state_q == ST_INTERP),
    .a_i     (s1a_q),
    .b_i     ($signed(rdata_a)),
    .w_i     (frac),
    .blend_o (wa)
  );

  wto_blend u_interp_b (
    .clk_i   (clk_i),
    .en_i    (state_q == ST_INTERP),
    .a_i     (s1b_q),
    .b_i     ($signed(rdata_b)),
    .w_i     (frac),
    .blend_o (wb)
  );

  // Crossfade lands directly in the output register
  wto_blend u_mix (
    .clk_i   (clk_i),
    .en_i    ((state_q == ST_MIX) && out_free),
    .a_i     (wa),
    .b_i     (wb),
    .w_i     (cfg.wave_mix),
    .blend_o (sample_o)
  );

  // Sequencer, phase accumulator and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
    end else begin
      // Output word: loaded by the crossfade, dropped once taken
      if ((state_q == ST_MIX) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_TICK: begin
                phase_q <= phase_q + cfg.phase_increment;
                state_q <= ST_MUL;
              end
              CMD_PHASE_RST: begin
                if (!cfg.free_running) begin
                  phase_q <= cfg.start_phase;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL:    state_q <= ST_RD1;
        ST_RD1:    state_q <= ST_RD2;
        ST_RD2:    state_q <= ST_INTERP;
        ST_INTERP: state_q <= ST_MIX;
        ST_MIX: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= phase_q + fm_phase_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_RD1) begin
      i2_q <= i2_d;
    end
    if (state_q == ST_RD2) begin
      s1a_q <= $signed(rdata_a);
      s1b_q <= $signed(rdata_b);
    end
  end

endmodule

>>> design/wto_ram.sv
module wto_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/wto_blend.sv
module wto_blend
  import wto_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] a_i,
  input  logic signed [SAMPLE_BITS-1:0] b_i,
  input  logic        [FRAC_W-1:0]      w_i,
  output logic signed [SAMPLE_BITS-1:0] blend_o
);

  localparam int DW   = SAMPLE_BITS + 1;
  localparam int PW   = DW + FRAC_W + 1;
  localparam int HALF = 1 << (FRAC_W - 1);

  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          sum;
  logic signed [PW-1:0]          res;
  logic signed [SAMPLE_BITS-1:0] blend_q;

  // a*(1-w) + b*w rewritten as a + (b-a)*w, rounded half up
  assign diff = $signed({b_i[SAMPLE_BITS-1], b_i}) - $signed({a_i[SAMPLE_BITS-1], a_i});
  assign prod = diff * $signed({1'b0, w_i});
  assign sum  = prod + PW'(HALF);
  assign res  = $signed({{(PW-SAMPLE_BITS){a_i[SAMPLE_BITS-1]}}, a_i}) + (sum >>> FRAC_W);

  // Convex combination, never leaves the sample range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blend_q <= res[SAMPLE_BITS-1:0];
    end
  end

  assign blend_o = blend_q;

endmodule

>>> design/wto_regs.sv
module wto_regs
  import wto_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output wto_cfg_t           cfg_o
);

  wto_cfg_t             cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx   = paddr[PADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_increment <= '0;
      cfg_q.table_length    <= LEN_W'(TABLE_DEPTH);
      cfg_q.wave_mix        <= '0;
      cfg_q.start_phase     <= '0;
      cfg_q.free_running    <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_INC:   cfg_q.phase_increment <= pwdata[PHASE_W-1:0];
        REG_LEN:   cfg_q.table_length    <= pwdata[LEN_W-1:0];
        REG_MIX:   cfg_q.wave_mix        <= pwdata[FRAC_W-1:0];
        REG_START: cfg_q.start_phase     <= pwdata[PHASE_W-1:0];
        REG_FREE:  cfg_q.free_running    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_INC:   prdata = PDATA_W'(cfg_q.phase_increment);
      REG_LEN:   prdata = PDATA_W'(cfg_q.table_length);
      REG_MIX:   prdata = PDATA_W'(cfg_q.wave_mix);
      REG_START: prdata = PDATA_W'(cfg_q.start_phase);
      REG_FREE:  prdata = PDATA_W'(cfg_q.free_running);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/wto_checker.sv
`include "wavetable_oscillator_core_defines.svh"

module wto_checker
  import wto_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [1:0]             command_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] sample_o
);

  logic in_acc;
  logic tick_acc;
  logic tick_idle;
  logic out_wait;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign tick_acc  = in_acc && (command_i == CMD_TICK);
  assign tick_idle = tick_acc && !out_valid_o;
  assign out_wait  = out_valid_o && out_stall_i;

  // A waiting word holds until taken
  `WTO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(sample_o))

  // A tick occupies the input side on the next cycle
  `WTO_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, tick_acc, in_stall_o)

  // Writes and phase resets give no result
  `WTO_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, in_acc && !tick_acc && !out_valid_o, !out_valid_o)

  // With the output empty, a tick result shows after the multiply, read, interpolate and crossfade states
  `WTO_ASSERT_IMPL(a_tick_latency, clk_i, rst_ni, tick_idle, ##5 !out_valid_o ##1 out_valid_o)

endmodule

bind wavetable_oscillator_core wto_checker u_wto_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_o    (sample_o)
);
